// ===== rtl/psf_pkg.sv =====
// Shared types, constants and helpers for the pursuit steering force pipeline.
package psf_pkg;

  localparam int ISQ_STEPS  = 32;
  localparam int UDIV_STEPS = 31;
  localparam int UNIT_LAT   = 6 + ISQ_STEPS + UDIV_STEPS;
  localparam int TDIV_STEPS = 32;

  localparam logic signed [15:0] LIM_RESET = -16'sd31130;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [30:0]        smax;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] evx;
    logic signed [31:0] evy;
  } item_t;

  typedef struct packed {
    logic [30:0] nx;
    logic [30:0] ny;
    logic        sx;
    logic        sy;
    logic        zero;
    logic        rsh;
    logic [5:0]  sh;
  } usd_t;

  typedef struct packed {
    logic [31:0] rx;
    logic [31:0] ry;
    logic [30:0] qx;
    logic [30:0] qy;
    logic [31:0] dv;
    logic [62:0] lo;
    usd_t        sd;
  } udv_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] lo;
    logic [31:0] q;
    logic [33:0] den;
    logic        dz;
    logic        ov;
    logic        dir;
    item_t       it;
  } tdv_t;

  typedef struct packed {
    logic [30:0]        smax;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               dir;
  } fin_t;

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -34'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/psf_unit.sv =====
// Pipelined unit vector and vector length unit with square root and dividers.
module psf_unit (
  input  logic                clk,
  input  logic                en,
  input  logic signed [63:0]  x_in,
  input  logic signed [63:0]  y_in,
  output logic signed [31:0]  ux_out,
  output logic signed [31:0]  uy_out,
  output logic [62:0]         len_out
);
  import psf_pkg::*;

  logic [63:0] mx, my;
  logic [61:0] ax_a_r, ay_a_r;
  logic        sx_a_r, sy_a_r;

  assign mx = x_in[63] ? 64'(-x_in) : 64'(x_in);
  assign my = y_in[63] ? 64'(-y_in) : 64'(y_in);

  always_ff @(posedge clk) begin
    if (en) begin
      ax_a_r <= mx[61:0];
      ay_a_r <= my[61:0];
      sx_a_r <= x_in[63];
      sy_a_r <= y_in[63];
    end
  end

  logic [61:0] m_b;
  logic [5:0]  pos_b;
  logic [61:0] ax_b_r, ay_b_r;
  logic [5:0]  pos_b_r;
  logic        zero_b_r, sx_b_r, sy_b_r;

  always_comb begin
    m_b   = (ax_a_r > ay_a_r) ? ax_a_r : ay_a_r;
    pos_b = '0;
    for (int i = 0; i < 62; i++) begin
      if (m_b[i]) pos_b = 6'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_b_r   <= ax_a_r;
      ay_b_r   <= ay_a_r;
      pos_b_r  <= pos_b;
      zero_b_r <= (m_b == '0);
      sx_b_r   <= sx_a_r;
      sy_b_r   <= sy_a_r;
    end
  end

  logic        rsh_c;
  logic [5:0]  sh_c;
  logic [61:0] nxw, nyw;
  usd_t        sd_c_r;

  always_comb begin
    rsh_c = (pos_b_r >= 6'd30);
    sh_c  = rsh_c ? (pos_b_r - 6'd30) : (6'd30 - pos_b_r);
    nxw   = rsh_c ? (ax_b_r >> sh_c) : (ax_b_r << sh_c);
    nyw   = rsh_c ? (ay_b_r >> sh_c) : (ay_b_r << sh_c);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_c_r.nx   <= nxw[30:0];
      sd_c_r.ny   <= nyw[30:0];
      sd_c_r.sx   <= sx_b_r;
      sd_c_r.sy   <= sy_b_r;
      sd_c_r.zero <= zero_b_r;
      sd_c_r.rsh  <= rsh_c;
      sd_c_r.sh   <= sh_c;
    end
  end

  logic [61:0] sqx_d_r, sqy_d_r;
  usd_t        sd_d_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_d_r <= 62'(sd_c_r.nx) * 62'(sd_c_r.nx);
      sqy_d_r <= 62'(sd_c_r.ny) * 62'(sd_c_r.ny);
      sd_d_r  <= sd_c_r;
    end
  end

  logic [62:0] n_r   [0:ISQ_STEPS];
  logic [62:0] r_r   [0:ISQ_STEPS];
  usd_t        isd_r [0:ISQ_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0]   <= {1'b0, sqx_d_r} + {1'b0, sqy_d_r};
      r_r[0]   <= '0;
      isd_r[0] <= sd_d_r;
    end
  end

  for (genvar i = 0; i < ISQ_STEPS; i++) begin : g_isq
    localparam logic [62:0] BIT = 63'd1 << (62 - 2 * i);
    logic [62:0] trial;
    logic        take;
    assign trial = r_r[i] + BIT;
    assign take  = (n_r[i] >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[i+1]   <= take ? (n_r[i] - trial) : n_r[i];
        r_r[i+1]   <= take ? ((r_r[i] >> 1) + BIT) : (r_r[i] >> 1);
        isd_r[i+1] <= isd_r[i];
      end
    end
  end

  udv_t dv_r [0:UDIV_STEPS-1];

  for (genvar j = 0; j < UDIV_STEPS; j++) begin : g_div
    udv_t        pv, dn;
    logic [32:0] tx, ty;
    logic        kx, ky;
    if (j == 0) begin : g_first
      always_comb begin
        pv.rx = {2'b00, isd_r[ISQ_STEPS].nx[30:1]};
        pv.ry = {2'b00, isd_r[ISQ_STEPS].ny[30:1]};
        pv.qx = '0;
        pv.qy = '0;
        pv.dv = r_r[ISQ_STEPS][31:0];
        pv.sd = isd_r[ISQ_STEPS];
        pv.lo = isd_r[ISQ_STEPS].rsh ? (63'(r_r[ISQ_STEPS][31:0]) << isd_r[ISQ_STEPS].sh)
                                     : (63'(r_r[ISQ_STEPS][31:0]) >> isd_r[ISQ_STEPS].sh);
      end
      assign tx = {pv.rx, pv.sd.nx[0]};
      assign ty = {pv.ry, pv.sd.ny[0]};
    end else begin : g_next
      assign pv = dv_r[j-1];
      assign tx = {pv.rx, 1'b0};
      assign ty = {pv.ry, 1'b0};
    end
    assign kx = (tx >= {1'b0, pv.dv});
    assign ky = (ty >= {1'b0, pv.dv});
    always_comb begin
      dn    = pv;
      dn.rx = kx ? 32'(tx - {1'b0, pv.dv}) : tx[31:0];
      dn.ry = ky ? 32'(ty - {1'b0, pv.dv}) : ty[31:0];
      dn.qx = {pv.qx[29:0], kx};
      dn.qy = {pv.qy[29:0], ky};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[j] <= dn;
      end
    end
  end

  logic signed [31:0] qxs, qys;
  logic signed [31:0] ux_r, uy_r;
  logic [62:0]        len_r;

  assign qxs = $signed({1'b0, dv_r[UDIV_STEPS-1].qx});
  assign qys = $signed({1'b0, dv_r[UDIV_STEPS-1].qy});

  always_ff @(posedge clk) begin
    if (en) begin
      ux_r  <= dv_r[UDIV_STEPS-1].sd.zero ? '0 : (dv_r[UDIV_STEPS-1].sd.sx ? -qxs : qxs);
      uy_r  <= dv_r[UDIV_STEPS-1].sd.zero ? '0 : (dv_r[UDIV_STEPS-1].sd.sy ? -qys : qys);
      len_r <= dv_r[UDIV_STEPS-1].lo;
    end
  end

  assign ux_out  = ux_r;
  assign uy_out  = uy_r;
  assign len_out = len_r;

endmodule

// ===== rtl/pursuit_steering_force_core.sv =====
// Pursuit steering force core: fully pipelined pursuit decision, look-ahead and seek force.
// Throughput is one transaction per cycle; the two unit vector pipelines (69 stages each,
// bit-per-stage square root and division) and the 32-stage look-ahead divider set the depth.
// The whole pipeline holds while the output register is full and not taken.
// Synchronous active-low reset clears all valid bits and loads the cosine limit default.
module pursuit_steering_force_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pursuer_x, pursuer_y, pursuer_vx, pursuer_vy, pursuer_max_speed(31),
  // evader_x, evader_y, evader_vx, evader_vy, zero pad(1)
  input  logic [287:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // force_x, force_y
  output logic [63:0]  out_tdata,
  // chased_directly
  output logic [0:0]   out_tuser,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata
);
  import psf_pkg::*;

  logic               adv;
  logic signed [15:0] lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= LIM_RESET;
    end else if (cfg_we) begin
      lim_r <= cfg_wdata;
    end
  end

  logic                v0_r, vp_r, vq_r, vm_r, vs_r, vf1_r, vf2_r;
  logic [UNIT_LAT-1:0] vdl_r, vdl2_r;
  logic [TDIV_STEPS-1:0] vd_r;

  assign adv       = !vf2_r || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r   <= 1'b0;
      vdl_r  <= '0;
      vp_r   <= 1'b0;
      vq_r   <= 1'b0;
      vd_r   <= '0;
      vm_r   <= 1'b0;
      vs_r   <= 1'b0;
      vdl2_r <= '0;
      vf1_r  <= 1'b0;
      vf2_r  <= 1'b0;
    end else if (adv) begin
      v0_r   <= in_tvalid;
      vdl_r  <= {vdl_r[UNIT_LAT-2:0], v0_r};
      vp_r   <= vdl_r[UNIT_LAT-1];
      vq_r   <= vp_r;
      vd_r   <= {vd_r[TDIV_STEPS-2:0], vq_r};
      vm_r   <= vd_r[TDIV_STEPS-1];
      vs_r   <= vm_r;
      vdl2_r <= {vdl2_r[UNIT_LAT-2:0], vs_r};
      vf1_r  <= vdl2_r[UNIT_LAT-1];
      vf2_r  <= vf1_r;
    end
  end

  item_t s0_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r.px   <= in_tdata[31:0];
      s0_r.py   <= in_tdata[63:32];
      s0_r.vx   <= in_tdata[95:64];
      s0_r.vy   <= in_tdata[127:96];
      s0_r.smax <= in_tdata[158:128];
      s0_r.ex   <= in_tdata[190:159];
      s0_r.ey   <= in_tdata[222:191];
      s0_r.evx  <= in_tdata[254:223];
      s0_r.evy  <= in_tdata[286:255];
    end
  end

  logic signed [63:0] dx0, dy0;
  logic signed [31:0] hx, hy, ehx, ehy, tux, tuy;
  logic [62:0]        len_h, len_e, len_d;

  assign dx0 = 64'(s0_r.ex) - 64'(s0_r.px);
  assign dy0 = 64'(s0_r.ey) - 64'(s0_r.py);

  psf_unit u_head (
    .clk(clk), .en(adv), .x_in(64'(s0_r.vx)), .y_in(64'(s0_r.vy)),
    .ux_out(hx), .uy_out(hy), .len_out(len_h)
  );

  psf_unit u_ehead (
    .clk(clk), .en(adv), .x_in(64'(s0_r.evx)), .y_in(64'(s0_r.evy)),
    .ux_out(ehx), .uy_out(ehy), .len_out(len_e)
  );

  psf_unit u_dir (
    .clk(clk), .en(adv), .x_in(dx0), .y_in(dy0),
    .ux_out(tux), .uy_out(tuy), .len_out(len_d)
  );

  item_t dl_r [0:UNIT_LAT-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      dl_r[0] <= s0_r;
      for (int k = 1; k < UNIT_LAT; k++) begin
        dl_r[k] <= dl_r[k-1];
      end
    end
  end

  logic signed [63:0] p_ah1_r, p_ah2_r, p_c1_r, p_c2_r;
  logic [32:0]        p_dist_r;
  logic [33:0]        p_den_r;
  item_t              p_it_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_ah1_r  <= tux * hx;
      p_ah2_r  <= tuy * hy;
      p_c1_r   <= hx * ehx;
      p_c2_r   <= hy * ehy;
      p_dist_r <= len_d[32:0];
      p_den_r  <= 34'(dl_r[UNIT_LAT-1].smax) + 34'(len_e[32:0]) + 34'(len_h[0] & 1'b0);
      p_it_r   <= dl_r[UNIT_LAT-1];
    end
  end

  logic signed [63:0] ahead_sum, cos_sum, lim_ext;
  logic [48:0]        dvd;
  tdv_t               q_r;

  assign ahead_sum = p_ah1_r + p_ah2_r;
  assign cos_sum   = p_c1_r + p_c2_r;
  assign lim_ext   = 64'(lim_r) <<< 45;
  assign dvd       = {p_dist_r, 16'b0};

  always_ff @(posedge clk) begin
    if (adv) begin
      q_r.rem <= 34'(dvd[48:32]);
      q_r.lo  <= dvd[31:0];
      q_r.q   <= '0;
      q_r.den <= p_den_r;
      q_r.dz  <= (p_den_r == '0);
      q_r.ov  <= ({17'b0, dvd} >= {p_den_r, 32'b0});
      q_r.dir <= (ahead_sum > 64'sd0) && (cos_sum < lim_ext);
      q_r.it  <= p_it_r;
    end
  end

  tdv_t d_r [0:TDIV_STEPS-1];

  for (genvar j = 0; j < TDIV_STEPS; j++) begin : g_tdiv
    tdv_t        pv, dn;
    logic [34:0] t;
    logic        k;
    if (j == 0) begin : g_first
      assign pv = q_r;
    end else begin : g_next
      assign pv = d_r[j-1];
    end
    assign t = {pv.rem, pv.lo[31]};
    assign k = (t >= {1'b0, pv.den});
    always_comb begin
      dn     = pv;
      dn.rem = k ? 34'(t - {1'b0, pv.den}) : t[33:0];
      dn.lo  = {pv.lo[30:0], 1'b0};
      dn.q   = {pv.q[30:0], k};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        d_r[j] <= dn;
      end
    end
  end

  tdv_t        dl_last;
  logic [31:0] tq, aevx, aevy;
  logic [63:0] m_ox_r, m_oy_r;
  logic        m_sx_r, m_sy_r, m_dir_r;
  item_t       m_it_r;

  assign dl_last = d_r[TDIV_STEPS-1];
  assign tq      = dl_last.dz ? '0 : (dl_last.ov ? '1 : dl_last.q);
  assign aevx    = dl_last.it.evx[31] ? 32'(-dl_last.it.evx) : 32'(dl_last.it.evx);
  assign aevy    = dl_last.it.evy[31] ? 32'(-dl_last.it.evy) : 32'(dl_last.it.evy);

  always_ff @(posedge clk) begin
    if (adv) begin
      m_ox_r  <= 64'(aevx) * 64'(tq);
      m_oy_r  <= 64'(aevy) * 64'(tq);
      m_sx_r  <= dl_last.it.evx[31];
      m_sy_r  <= dl_last.it.evy[31];
      m_dir_r <= dl_last.dir;
      m_it_r  <= dl_last.it;
    end
  end

  logic signed [50:0] offx, offy, tx_nxt, ty_nxt;
  logic signed [50:0] s_tx_r, s_ty_r;
  fin_t               s_fin_r;

  assign offx = m_sx_r ? -$signed({3'b0, m_ox_r[63:16]}) : $signed({3'b0, m_ox_r[63:16]});
  assign offy = m_sy_r ? -$signed({3'b0, m_oy_r[63:16]}) : $signed({3'b0, m_oy_r[63:16]});

  always_comb begin
    if (m_dir_r) begin
      tx_nxt = 51'(m_it_r.ex) - 51'(m_it_r.px);
      ty_nxt = 51'(m_it_r.ey) - 51'(m_it_r.py);
    end else begin
      tx_nxt = 51'(m_it_r.ex) + offx - 51'(m_it_r.px);
      ty_nxt = 51'(m_it_r.ey) + offy - 51'(m_it_r.py);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_tx_r       <= tx_nxt;
      s_ty_r       <= ty_nxt;
      s_fin_r.smax <= m_it_r.smax;
      s_fin_r.vx   <= m_it_r.vx;
      s_fin_r.vy   <= m_it_r.vy;
      s_fin_r.dir  <= m_dir_r;
    end
  end

  logic signed [31:0] ux, uy;

  psf_unit u_seek (
    .clk(clk), .en(adv), .x_in(64'(s_tx_r)), .y_in(64'(s_ty_r)),
    .ux_out(ux), .uy_out(uy), .len_out()
  );

  fin_t dl2_r [0:UNIT_LAT-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      dl2_r[0] <= s_fin_r;
      for (int k = 1; k < UNIT_LAT; k++) begin
        dl2_r[k] <= dl2_r[k-1];
      end
    end
  end

  logic [30:0] aux, auy;
  logic [60:0] f_px_r, f_py_r;
  logic        f_sx_r, f_sy_r;
  fin_t        f_fin_r;

  assign aux = ux[31] ? 31'(-ux) : 31'(ux);
  assign auy = uy[31] ? 31'(-uy) : 31'(uy);

  always_ff @(posedge clk) begin
    if (adv) begin
      f_px_r  <= 61'(aux) * 61'(dl2_r[UNIT_LAT-1].smax);
      f_py_r  <= 61'(auy) * 61'(dl2_r[UNIT_LAT-1].smax);
      f_sx_r  <= ux[31];
      f_sy_r  <= uy[31];
      f_fin_r <= dl2_r[UNIT_LAT-1];
    end
  end

  logic signed [33:0] scx, scy, fx, fy;
  logic [31:0]        out_fx_r, out_fy_r;
  logic               out_dir_r;

  assign scx = f_sx_r ? -$signed({3'b0, f_px_r[60:30]}) : $signed({3'b0, f_px_r[60:30]});
  assign scy = f_sy_r ? -$signed({3'b0, f_py_r[60:30]}) : $signed({3'b0, f_py_r[60:30]});
  assign fx  = scx - 34'(f_fin_r.vx);
  assign fy  = scy - 34'(f_fin_r.vy);

  always_ff @(posedge clk) begin
    if (adv) begin
      out_fx_r  <= sat32(fx);
      out_fy_r  <= sat32(fy);
      out_dir_r <= f_fin_r.dir;
    end
  end

  assign out_tvalid = vf2_r;
  assign out_tdata  = {out_fy_r, out_fx_r};
  assign out_tuser  = out_dir_r;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(v0_r) && $stable(vdl_r) && $stable(vd_r))
    else $error("Pipeline valid bits moved while the output was stalled.");

  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v0_r)
    else $error("An accepted input transaction did not enter the first stage.");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !v0_r)
    else $error("Reset did not clear the pipeline valid bits.");
`endif

endmodule

// ===== test/pursuit_steering_force_core_test.sv =====
// Testbench for the pursuit steering force core: directed and random checks of the force and chased_directly.
`timescale 1ns / 1ps

module pursuit_steering_force_core_test;
  import psf_pkg::*;

  typedef struct {
    logic [31:0] fx;
    logic [31:0] fy;
    logic        direct;
  } force_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [287:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_we;
  logic [15:0]  cfg_wdata;

  logic signed [15:0] cos_limit;
  force_t             pending_forces[$];
  int                 fail_count;
  int                 idle_cycles;
  int                 ready_hold;
  bit                 gaps_on;

  pursuit_steering_force_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] magnitude(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic heading(input logic signed [63:0] x, input logic signed [63:0] y,
                         output logic signed [63:0] ux, output logic signed [63:0] uy);
    logic [63:0] ax, ay, m, len, qx, qy;
    ax = magnitude(x);
    ay = magnitude(y);
    m = ax > ay ? ax : ay;
    if (m == 0) begin
      ux = 0;
      uy = 0;
      return;
    end
    while (m >= (64'd1 << 31)) begin
      ax = ax >> 1; ay = ay >> 1; m = m >> 1;
    end
    while (m < (64'd1 << 30)) begin
      ax = ax << 1; ay = ay << 1; m = m << 1;
    end
    len = int_sqrt(ax * ax + ay * ay);
    qx = (ax << 30) / len;
    qy = (ay << 30) / len;
    ux = x < 0 ? -$signed(qx) : $signed(qx);
    uy = y < 0 ? -$signed(qy) : $signed(qy);
  endtask

  function automatic logic [63:0] distance(input logic signed [63:0] x,
                                           input logic signed [63:0] y);
    logic [63:0] ax, ay;
    int k;
    ax = magnitude(x);
    ay = magnitude(y);
    k = 0;
    while (ax >= (64'd1 << 31) || ay >= (64'd1 << 31)) begin
      ax = ax >> 1; ay = ay >> 1; k++;
    end
    return int_sqrt(ax * ax + ay * ay) << k;
  endfunction

  function automatic logic signed [63:0] scaled(input logic signed [63:0] v,
                                                input logic [63:0] f, input int sh);
    logic [127:0] p;
    p = (128'(magnitude(v)) * f) >> sh;
    return v < 0 ? -$signed(p[63:0]) : $signed(p[63:0]);
  endfunction

  function automatic logic [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  task automatic predict_force(input item_t it, output force_t f);
    logic signed [63:0] px, py, vx, vy, ex, ey, evx, evy, dx, dy, tx, ty;
    logic signed [63:0] hx, hy, ehx, ehy, tux, tuy, ux, uy;
    logic [63:0] smax, sep_len, den, t;
    logic signed [127:0] dot_ahead, dot_cos, lim;
    px = it.px; py = it.py; vx = it.vx; vy = it.vy;
    ex = it.ex; ey = it.ey; evx = it.evx; evy = it.evy;
    smax = {33'd0, it.smax};
    heading(vx, vy, hx, hy);
    heading(evx, evy, ehx, ehy);
    dx = ex - px;
    dy = ey - py;
    heading(dx, dy, tux, tuy);
    dot_ahead = 128'(tux) * hx + 128'(tuy) * hy;
    dot_cos = 128'(hx) * ehx + 128'(hy) * ehy;
    lim = 128'(cos_limit) <<< 45;
    f.direct = (dot_ahead > 0) && (dot_cos < lim);
    if (f.direct) begin
      tx = dx;
      ty = dy;
    end else begin
      sep_len = distance(dx, dy);
      den = smax + distance(evx, evy);
      t = 0;
      if (den != 0) begin
        t = (sep_len << 16) / den;
        if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
      end
      tx = ex + scaled(evx, t, 16) - px;
      ty = ey + scaled(evy, t, 16) - py;
    end
    heading(tx, ty, ux, uy);
    f.fx = clamp32(scaled(ux, smax, 30) - vx);
    f.fy = clamp32(scaled(uy, smax, 30) - vy);
  endtask

  function automatic int gap_length();
    if (!gaps_on || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  task automatic send_pair(input item_t it);
    force_t f;
    repeat (gap_length()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, it.evy, it.evx, it.ey, it.ex, it.smax, it.vy, it.vx, it.py, it.px};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_force(it, f);
    pending_forces.push_back(f);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_limit(input logic signed [15:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cos_limit = v;
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 200000) - 100000;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sh8000_0000;
      3: return 0;
      default: return $urandom;
    endcase
  endfunction

  function automatic item_t rand_pair(input bit chase);
    item_t it;
    it.px = rand_word(); it.py = rand_word();
    it.vx = rand_word(); it.vy = rand_word();
    it.ex = rand_word(); it.ey = rand_word();
    it.evx = rand_word(); it.evy = rand_word();
    it.smax = $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 1 << 22));
    if (chase) begin
      // Evader ahead and heading toward the pursuer, at moderate scale.
      it.px = $urandom_range(0, 1 << 24) - (1 << 23);
      it.py = $urandom_range(0, 1 << 24) - (1 << 23);
      it.vx = $urandom_range(1, 1 << 20);
      it.vy = $urandom_range(0, 1 << 18) - (1 << 17);
      it.ex = it.px + $urandom_range(1, 1 << 22);
      it.ey = it.py + $urandom_range(0, 1 << 20) - (1 << 19);
      it.evx = -$signed(32'($urandom_range(1, 1 << 20)));
      it.evy = $urandom_range(0, 1 << 16) - (1 << 15);
    end
    return it;
  endfunction

  task automatic test_directed();
    item_t it;
    it = '0;
    send_pair(it);
    it.vx = 32'sh0001_0000; it.ex = 32'sh000A_0000; it.evx = -32'sh0001_0000;
    it.smax = 31'h0002_0000;
    send_pair(it);
    it.evx = 32'sh0001_0000;
    send_pair(it);
    it = '0;
    it.evx = 32'sh0001_0000; it.ex = 32'sh0001_0000;
    send_pair(it);
    it = '0;
    it.px = 32'sh7FFF_FFFF; it.py = 32'sh8000_0000; it.ex = 32'sh8000_0000;
    it.ey = 32'sh7FFF_FFFF; it.vx = 32'sh8000_0000; it.vy = 32'sh7FFF_FFFF;
    it.smax = 31'h7FFF_FFFF;
    send_pair(it);
    it.evx = 32'sh8000_0000; it.evy = 32'sh8000_0000;
    send_pair(it);
    it = '0;
    it.ex = 32'sh7FFF_FFFF; it.evx = 32'sh7FFF_FFFF; it.smax = 31'd1;
    send_pair(it);
    it = '0;
    it.px = 32'sh0001_0000; it.ex = 32'sh0001_0000; it.vx = 32'sh8000_0000;
    it.smax = 31'h7FFF_FFFF;
    send_pair(it);
    it = '1;
    send_pair(it);
    repeat (8) send_pair(rand_pair(1));
  endtask

  task automatic test_limits();
    logic signed [15:0] lims[4];
    lims = '{16'sh8000, 16'sh7FFF, 16'sh0000, -16'sd31130};
    foreach (lims[i]) begin
      write_limit(lims[i]);
      repeat (40) send_pair(rand_pair($urandom_range(0, 1)));
    end
  endtask

  task automatic test_random();
    for (int i = 0; i < 700; i++) begin
      if (i == 350) drain();
      send_pair(rand_pair($urandom_range(0, 3) != 0));
    end
  endtask

  task automatic test_no_gaps();
    gaps_on = 1'b0;
    repeat (40) send_pair(rand_pair(1));
    gaps_on = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_forces.size() == 0) begin
          $display("%0t: unexpected output %h %b", $time, out_tdata, out_tuser);
          fail_count++;
        end else begin
          force_t f;
          f = pending_forces.pop_front();
          if (out_tdata[31:0] !== f.fx) begin
            $display("%0t: force_x expected %h actual %h", $time, f.fx, out_tdata[31:0]);
            fail_count++;
          end
          if (out_tdata[63:32] !== f.fy) begin
            $display("%0t: force_y expected %h actual %h", $time, f.fy, out_tdata[63:32]);
            fail_count++;
          end
          if (out_tuser[0] !== f.direct) begin
            $display("%0t: chased_directly expected %b actual %b", $time, f.direct,
                     out_tuser[0]);
            fail_count++;
          end
        end
      end
      if (ready_hold > 0) begin
        out_tready <= 1'b0;
        ready_hold <= ready_hold - 1;
      end else begin
        out_tready <= 1'b1;
        ready_hold <= gap_length();
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > 20000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    fail_count = 0;
    idle_cycles = 0;
    ready_hold = 0;
    gaps_on = 1'b1;
    cos_limit = LIM_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_limits();
    test_random();
    test_no_gaps();
    drain();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
